>>> rtl/core/tcgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tcgr_pkg;

    localparam int GLYPH_ROWS  = 7;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0]  TEXT_COLS   = 8'd80;
    localparam logic [7:0]  TEXT_ROWS   = 8'd25;
    localparam logic [7:0]  FIRST_GLYPH = 8'h21;
    localparam logic [7:0]  LAST_GLYPH  = 8'h7E;
    localparam logic [3:0]  MAX_CHAN_SIZE = 4'd8;

    localparam logic        RST_GRAPHICS = 1'b0;
    localparam logic [7:0]  RST_COLUMNS  = 8'd80;
    localparam logic [7:0]  RST_ROWS     = 8'd25;
    localparam logic [15:0] RST_PITCH    = 16'd2560;
    localparam logic [2:0]  RST_BPP      = 3'd4;
    localparam logic [8:0]  RST_RED      = 9'd264;
    localparam logic [8:0]  RST_GREEN    = 9'd136;
    localparam logic [8:0]  RST_BLUE     = 9'd8;
    localparam logic [2:0]  RAW_BPP      = 3'd4;

    typedef enum logic [2:0] {
        CFG_GRAPHICS = 3'd0,
        CFG_COLUMNS  = 3'd1,
        CFG_ROWS     = 3'd2,
        CFG_PITCH    = 3'd3,
        CFG_BPP      = 3'd4,
        CFG_RED      = 3'd5,
        CFG_GREEN    = 3'd6,
        CFG_BLUE     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        graphics_mode;
        logic [7:0]  columns_in_use;
        logic [7:0]  rows_in_use;
        logic [15:0] line_pitch;
        logic [2:0]  bytes_per_pixel;
        logic [8:0]  red_format;
        logic [8:0]  green_format;
        logic [8:0]  blue_format;
    } t_cfg;

    typedef struct packed {
        logic [7:0] cell_column;
        logic [7:0] cell_row;
        logic [7:0] char_code;
        logic [7:0] attribute;
    } t_cell;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_MUL,
        S_PACK,
        S_ROWS
    } t_state;

    typedef logic [0:GLYPH_ROWS-1][4:0] t_glyph;

    localparam logic [23:0] PALETTE [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    localparam t_glyph FONT [94] = '{
        '{5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04}, '{5'h0A,5'h0A,5'h00,5'h00,5'h00,5'h00,5'h00},
        '{5'h0A,5'h1F,5'h0A,5'h0A,5'h1F,5'h0A,5'h00}, '{5'h04,5'h0F,5'h14,5'h0E,5'h05,5'h1E,5'h04},
        '{5'h19,5'h1A,5'h02,5'h04,5'h08,5'h0B,5'h13}, '{5'h0C,5'h12,5'h14,5'h08,5'h15,5'h12,5'h0D},
        '{5'h04,5'h04,5'h00,5'h00,5'h00,5'h00,5'h00}, '{5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02},
        '{5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08}, '{5'h00,5'h15,5'h0E,5'h1F,5'h0E,5'h15,5'h00},
        '{5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00}, '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h06,5'h04},
        '{5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00}, '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h06,5'h06},
        '{5'h01,5'h02,5'h04,5'h08,5'h10,5'h00,5'h00},
        '{5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E}, '{5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
        '{5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F}, '{5'h1E,5'h01,5'h01,5'h0E,5'h01,5'h01,5'h1E},
        '{5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02}, '{5'h1F,5'h10,5'h10,5'h1E,5'h01,5'h01,5'h1E},
        '{5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E}, '{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
        '{5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E}, '{5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C},
        '{5'h00,5'h06,5'h06,5'h00,5'h06,5'h06,5'h00}, '{5'h06,5'h06,5'h00,5'h06,5'h04,5'h08,5'h00},
        '{5'h01,5'h02,5'h04,5'h08,5'h04,5'h02,5'h01}, '{5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00,5'h00},
        '{5'h10,5'h08,5'h04,5'h02,5'h04,5'h08,5'h10}, '{5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04},
        '{5'h0E,5'h11,5'h17,5'h15,5'h17,5'h10,5'h0E},
        '{5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11}, '{5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E},
        '{5'h0F,5'h10,5'h10,5'h10,5'h10,5'h10,5'h0F}, '{5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E},
        '{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F}, '{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10},
        '{5'h0F,5'h10,5'h10,5'h17,5'h11,5'h11,5'h0F}, '{5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
        '{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h1F}, '{5'h07,5'h02,5'h02,5'h02,5'h12,5'h12,5'h0C},
        '{5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11}, '{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F},
        '{5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11}, '{5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11},
        '{5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E}, '{5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10},
        '{5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D}, '{5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11},
        '{5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E}, '{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
        '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E}, '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04},
        '{5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11}, '{5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11},
        '{5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04}, '{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F},
        '{5'h0E,5'h08,5'h08,5'h08,5'h08,5'h08,5'h0E}, '{5'h10,5'h08,5'h04,5'h02,5'h01,5'h00,5'h00},
        '{5'h0E,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0E}, '{5'h04,5'h0A,5'h11,5'h00,5'h00,5'h00,5'h00},
        '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F}, '{5'h04,5'h02,5'h00,5'h00,5'h00,5'h00,5'h00},
        '{5'h00,5'h00,5'h0E,5'h01,5'h0F,5'h11,5'h0F}, '{5'h10,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h1E},
        '{5'h00,5'h00,5'h0F,5'h10,5'h10,5'h10,5'h0F}, '{5'h01,5'h01,5'h0F,5'h11,5'h11,5'h11,5'h0F},
        '{5'h00,5'h00,5'h0E,5'h11,5'h1F,5'h10,5'h0E}, '{5'h06,5'h09,5'h08,5'h1C,5'h08,5'h08,5'h08},
        '{5'h00,5'h00,5'h0F,5'h11,5'h0F,5'h01,5'h0E}, '{5'h10,5'h10,5'h16,5'h19,5'h11,5'h11,5'h11},
        '{5'h04,5'h00,5'h0C,5'h04,5'h04,5'h04,5'h0E}, '{5'h02,5'h00,5'h06,5'h02,5'h02,5'h12,5'h0C},
        '{5'h10,5'h10,5'h12,5'h14,5'h18,5'h14,5'h12}, '{5'h0C,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E},
        '{5'h00,5'h00,5'h1A,5'h15,5'h15,5'h15,5'h15}, '{5'h00,5'h00,5'h16,5'h19,5'h11,5'h11,5'h11},
        '{5'h00,5'h00,5'h0E,5'h11,5'h11,5'h11,5'h0E}, '{5'h00,5'h00,5'h1E,5'h11,5'h1E,5'h10,5'h10},
        '{5'h00,5'h00,5'h0F,5'h11,5'h0F,5'h01,5'h01}, '{5'h00,5'h00,5'h17,5'h18,5'h10,5'h10,5'h10},
        '{5'h00,5'h00,5'h0F,5'h10,5'h0E,5'h01,5'h1E}, '{5'h08,5'h08,5'h1C,5'h08,5'h08,5'h09,5'h06},
        '{5'h00,5'h00,5'h11,5'h11,5'h11,5'h13,5'h0D}, '{5'h00,5'h00,5'h11,5'h11,5'h11,5'h0A,5'h04},
        '{5'h00,5'h00,5'h11,5'h15,5'h15,5'h1B,5'h11}, '{5'h00,5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11},
        '{5'h00,5'h00,5'h11,5'h11,5'h0F,5'h01,5'h0E}, '{5'h00,5'h00,5'h1F,5'h02,5'h04,5'h08,5'h1F},
        '{5'h02,5'h04,5'h04,5'h08,5'h04,5'h04,5'h02}, '{5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
        '{5'h08,5'h04,5'h04,5'h02,5'h04,5'h04,5'h08}, '{5'h00,5'h09,5'h16,5'h00,5'h00,5'h00,5'h00}
    };

    // channel multiplier (2^size - 1), size clamped to eight
    function automatic logic [7:0] chan_scale(input logic [8:0] fmt);
        logic [3:0] sz;
        logic [8:0] full;
        sz   = (fmt[3:0] > MAX_CHAN_SIZE) ? MAX_CHAN_SIZE : fmt[3:0];
        full = (9'd1 << sz) - 9'd1;
        return full[7:0];
    endfunction

    // exact p / 255 for p below 65280, then placed at the channel position
    function automatic logic [31:0] chan_place(input logic [15:0] p, input logic [8:0] fmt);
        logic [16:0] t;
        logic [31:0] q;
        t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
        q = {24'd0, t[15:8]};
        return q << fmt[8:4];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/tcgr_cell_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tcgr_cell_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_column;
    logic [7:0] cell_row;
    logic [7:0] char_code;
    logic [7:0] attribute;

    modport source(output valid, cell_column, cell_row, char_code, attribute, input ready);
    modport sink(input valid, cell_column, cell_row, char_code, attribute, output ready);
endinterface
`default_nettype wire

>>> rtl/core/tcgr_row_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tcgr_row_if;
    logic        valid;
    logic        ready;
    logic [26:0] byte_offset;
    logic [7:0]  foreground_mask;
    logic [31:0] foreground_pixel;
    logic [31:0] background_pixel;
    logic [15:0] text_word;
    logic        is_text_write;
    logic        last_row;

    modport source(output valid, byte_offset, foreground_mask, foreground_pixel,
                   background_pixel, text_word, is_text_write, last_row, input ready);
    modport sink(input valid, byte_offset, foreground_mask, foreground_pixel,
                 background_pixel, text_word, is_text_write, last_row, output ready);
endinterface
`default_nettype wire

>>> rtl/core/tcgr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tcgr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/tcgr_cell_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module tcgr_cell_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tcgr_pkg::t_cfg i_cfg,
    tcgr_cell_if.sink          i_cell,
    input  wire logic          i_pop,
    output logic               o_nonempty,
    output tcgr_pkg::t_cell    o_cell
);
    import tcgr_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          in_grid, fire, wr;
    t_cell         wdata;

    assign wdata = '{cell_column: i_cell.cell_column, cell_row: i_cell.cell_row,
                     char_code: i_cell.char_code, attribute: i_cell.attribute};

    always_comb begin
        if (i_cfg.graphics_mode) begin
            in_grid = (i_cell.cell_column < i_cfg.columns_in_use) &&
                      (i_cell.cell_row < i_cfg.rows_in_use);
        end else begin
            in_grid = (i_cell.cell_column < TEXT_COLS) && (i_cell.cell_row < TEXT_ROWS);
        end
    end

    assign i_cell.ready = (r_count != CW'(QUEUE_DEPTH));
    assign fire         = i_cell.valid && i_cell.ready;
    // drop cells off the grid at the door
    assign wr           = fire && in_grid;
    assign o_nonempty   = (r_count != '0);
    assign n_count      = r_count + CW'(wr) - CW'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr)    r_wr_ptr <= r_wr_ptr + AW'(1);
            if (i_pop) r_rd_ptr <= r_rd_ptr + AW'(1);
            r_count <= n_count;
        end
    end

    tcgr_ram #(.WIDTH($bits(t_cell)), .DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (wr),
        .i_waddr(r_wr_ptr),
        .i_wdata(wdata),
        .i_raddr(r_rd_ptr),
        .o_rdata(o_cell)
    );

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH)) else $error("cell queue overfilled");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0) else $error("pop from empty cell queue");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr)) else $error("queue pointers skewed");
endmodule
`default_nettype wire

>>> rtl/core/tcgr_row_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module tcgr_row_engine #(
    parameter int CELL_WIDTH  = 8,
    parameter int CELL_HEIGHT = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tcgr_pkg::t_cfg i_cfg,
    input  wire logic           i_nonempty,
    input  wire tcgr_pkg::t_cell i_cell,
    output logic                o_pop,
    tcgr_row_if.source          o_row
);
    import tcgr_pkg::*;

    localparam int YW  = $clog2(CELL_HEIGHT);
    localparam int LW  = 8 + YW;
    localparam int TOP = (CELL_HEIGHT - GLYPH_ROWS) / 2;
    localparam logic [YW-1:0] Y_LAST = YW'(CELL_HEIGHT - 1);

    t_state r_state, n_state;

    logic [7:0]  r_col, r_row, r_code, r_attr;
    logic [23:0] r_fg_rgb, r_bg_rgb;
    logic [15:0] r_prod [6];
    logic [26:0] r_line_off;
    logic [14:0] r_col_off;
    logic [31:0] r_fg_px, r_bg_px;
    logic [26:0] r_off;
    logic [YW-1:0] r_y;
    logic        r_text;

    logic        r_ov;
    logic [26:0] r_o_off;
    logic [7:0]  r_o_mask;
    logic [31:0] r_o_fg, r_o_bg;
    logic [15:0] r_o_word;
    logic        r_o_text, r_o_last;

    logic        out_free, emit, last_beat;
    logic [7:0]  mask;
    logic [4:0]  bits;
    logic [7:0]  fidx;
    logic [YW:0] gline;
    logic [7:0]  scl [3];
    logic [LW-1:0] line0;
    logic [10:0] text_off;

    assign out_free  = !r_ov || o_row.ready;
    assign last_beat = r_text || (r_y == Y_LAST);

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        emit    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_nonempty) begin
                    o_pop   = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: n_state = i_cfg.graphics_mode ? S_MUL : S_ROWS;
            S_MUL:   n_state = S_PACK;
            S_PACK:  n_state = S_ROWS;
            S_ROWS: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (last_beat) begin
                        // chain into the next queued cell without passing through S_IDLE
                        if (i_nonempty) begin
                            o_pop   = 1'b1;
                            n_state = S_FETCH;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign scl[0] = chan_scale(i_cfg.red_format);
    assign scl[1] = chan_scale(i_cfg.green_format);
    assign scl[2] = chan_scale(i_cfg.blue_format);
    assign line0  = LW'(r_row) * LW'(CELL_HEIGHT);
    assign text_off = 11'(r_row) * 11'(TEXT_COLS) + 11'(r_col);

    // glyph row for the current pixel row
    always_comb begin
        gline = {1'b0, r_y} - (YW+1)'(TOP);
        fidx  = r_code - FIRST_GLYPH;
        bits  = '0;
        if (r_code >= FIRST_GLYPH && r_code <= LAST_GLYPH &&
            int'(r_y) >= TOP && int'(r_y) < TOP + GLYPH_ROWS) begin
            bits = FONT[fidx[6:0]][gline[2:0]];
        end
        mask = '0;
        for (int x = 1; x <= 5; x++) begin
            if (x < CELL_WIDTH) mask[x] = bits[5-x];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_FETCH: begin
                r_col    <= i_cell.cell_column;
                r_row    <= i_cell.cell_row;
                r_code   <= i_cell.char_code;
                r_attr   <= i_cell.attribute;
                r_fg_rgb <= PALETTE[i_cell.attribute[3:0]];
                r_bg_rgb <= PALETTE[i_cell.attribute[7:4]];
                r_text   <= !i_cfg.graphics_mode;
                r_y      <= '0;
            end
            S_MUL: begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[k]   <= 16'(r_fg_rgb[23-8*k -: 8]) * 16'(scl[k]);
                    r_prod[k+3] <= 16'(r_bg_rgb[23-8*k -: 8]) * 16'(scl[k]);
                end
                r_line_off <= 27'(29'(line0) * 29'(i_cfg.line_pitch));
                r_col_off  <= 15'(r_col) * 15'(CELL_WIDTH) * 15'(i_cfg.bytes_per_pixel);
            end
            S_PACK: begin
                if (i_cfg.bytes_per_pixel == RAW_BPP) begin
                    r_fg_px <= {8'd0, r_fg_rgb};
                    r_bg_px <= {8'd0, r_bg_rgb};
                end else begin
                    r_fg_px <= chan_place(r_prod[0], i_cfg.red_format) |
                               chan_place(r_prod[1], i_cfg.green_format) |
                               chan_place(r_prod[2], i_cfg.blue_format);
                    r_bg_px <= chan_place(r_prod[3], i_cfg.red_format) |
                               chan_place(r_prod[4], i_cfg.green_format) |
                               chan_place(r_prod[5], i_cfg.blue_format);
                end
                r_off <= r_line_off + 27'(r_col_off);
            end
            S_ROWS: begin
                if (emit) begin
                    r_y   <= r_y + YW'(1);
                    r_off <= r_off + 27'(i_cfg.line_pitch);
                end
            end
            default: ;
        endcase

        if (emit) begin
            r_o_text <= r_text;
            r_o_last <= last_beat;
            if (r_text) begin
                r_o_off  <= 27'(text_off);
                r_o_mask <= '0;
                r_o_fg   <= '0;
                r_o_bg   <= '0;
                r_o_word <= {r_attr, r_code};
            end else begin
                r_o_off  <= r_off;
                r_o_mask <= mask;
                r_o_fg   <= r_fg_px;
                r_o_bg   <= r_bg_px;
                r_o_word <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_ov <= 1'b0;
        else if (emit)     r_ov <= 1'b1;
        else if (o_row.ready) r_ov <= 1'b0;
    end

    assign o_row.valid            = r_ov;
    assign o_row.byte_offset      = r_o_off;
    assign o_row.foreground_mask  = r_o_mask;
    assign o_row.foreground_pixel = r_o_fg;
    assign o_row.background_pixel = r_o_bg;
    assign o_row.text_word        = r_o_word;
    assign o_row.is_text_write    = r_o_text;
    assign o_row.last_row         = r_o_last;

    a_fetch_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> $past(o_pop)) else $error("fetch without pop");
    a_text_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_text) |-> (r_o_last && r_o_mask == '0)) else $error("bad text beat");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free) else $error("output register overrun");
endmodule
`default_nettype wire

>>> rtl/core/text_cell_glyph_renderer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Character cell renderer. Each accepted cell beat inside the grid yields CELL_HEIGHT
// row beats in graphics mode (byte offset, foreground mask, packed foreground and
// background pixels) or one text word beat in text mode; cells off the grid are
// swallowed. Cells wait in a four-entry queue held in a small RAM, so input is taken
// while rows are still being emitted. A graphics cell passes through set-up states
// (palette fetch, channel multiply, pack) before its row beats; a text cell goes from
// fetch to its single beat. The engine takes the next queued cell only after the last
// beat of the current one, and output stalls hold it; a cell finding the engine idle
// is popped and read from the queue RAM first, and beats leave through an output
// register. The user must write configuration through the plain write port only while
// the block is idle; the block itself does not enforce this.
module text_cell_glyph_renderer_top #(
    parameter int CELL_WIDTH  = 8,
    parameter int CELL_HEIGHT = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    tcgr_cell_if.sink        i_cell,
    tcgr_row_if.source       o_row
);
    import tcgr_pkg::*;

    t_cfg  r_cfg;
    t_cell q_cell;
    logic  pop, nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{graphics_mode: RST_GRAPHICS, columns_in_use: RST_COLUMNS,
                       rows_in_use: RST_ROWS, line_pitch: RST_PITCH,
                       bytes_per_pixel: RST_BPP, red_format: RST_RED,
                       green_format: RST_GREEN, blue_format: RST_BLUE};
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GRAPHICS: r_cfg.graphics_mode   <= i_cfg_data[0];
                CFG_COLUMNS:  r_cfg.columns_in_use  <= i_cfg_data[7:0];
                CFG_ROWS:     r_cfg.rows_in_use     <= i_cfg_data[7:0];
                CFG_PITCH:    r_cfg.line_pitch      <= i_cfg_data;
                CFG_BPP:      r_cfg.bytes_per_pixel <= i_cfg_data[2:0];
                CFG_RED:      r_cfg.red_format      <= i_cfg_data[8:0];
                CFG_GREEN:    r_cfg.green_format    <= i_cfg_data[8:0];
                CFG_BLUE:     r_cfg.blue_format     <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    tcgr_cell_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cell    (i_cell),
        .i_pop     (pop),
        .o_nonempty(nonempty),
        .o_cell    (q_cell)
    );

    tcgr_row_engine #(.CELL_WIDTH(CELL_WIDTH), .CELL_HEIGHT(CELL_HEIGHT)) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_nonempty(nonempty),
        .i_cell    (q_cell),
        .o_pop     (pop),
        .o_row     (o_row)
    );
endmodule
`default_nettype wire
